/* hw/rtl/mf7_pkg.sv */
`default_nettype none
package mf7_pkg;

  // Window geometry and field widths.
  localparam int WIN        = 7;
  localparam int NLINES     = WIN - 1;
  localparam int NWIN       = WIN * WIN;
  localparam int HALF       = WIN / 2;
  localparam int RANK       = NWIN / 2;
  localparam int PIX_W      = 8;
  localparam int COORD_W    = 10;
  localparam int CFG_W      = 11;
  localparam int IDX_W      = 2;
  localparam int CNT_W      = 6;
  localparam int MAX_HEIGHT = 1024;
  localparam int RESET_DIM  = 512;

  // Configuration register indexes.
  typedef enum logic [IDX_W-1:0] {
    REG_IMAGE_WIDTH  = 2'd0,
    REG_IMAGE_HEIGHT = 2'd1
  } cfg_reg_t;

  typedef logic [PIX_W-1:0] pix_t;

  // One complete window together with the position of its center pixel.
  typedef struct packed {
    pix_t [NWIN-1:0]    win;
    logic [COORD_W-1:0] ccol;
    logic [COORD_W-1:0] crow;
    logic               last;
  } win_item_t;

  // Counts the window pixels that match the prefix above bit b and have bit b clear.
  function automatic logic [CNT_W-1:0] count_low(input pix_t [NWIN-1:0] win,
                                                 input pix_t prefix, input int b);
    logic [CNT_W-1:0] cnt;
    pix_t mask;
    cnt  = '0;
    mask = PIX_W'(16'h00FF << (b + 1));
    for (int i = 0; i < NWIN; i++) begin
      if ((((win[i] ^ prefix) & mask) == '0) && !win[i][b]) begin
        cnt = cnt + CNT_W'(1);
      end
    end
    return cnt;
  endfunction

endpackage
`default_nettype wire

/* hw/rtl/mf7_pix_if.sv */
`default_nettype none
interface mf7_pix_if;
  logic       valid;
  logic       ready;
  logic [7:0] pixel;

  modport source (output valid, output pixel, input ready);
  modport sink (input valid, input pixel, output ready);
endinterface
`default_nettype wire

/* hw/rtl/mf7_res_if.sv */
`default_nettype none
interface mf7_res_if;
  logic       valid;
  logic       ready;
  logic [7:0] median_value;
  logic [9:0] center_col;
  logic [9:0] center_row;
  logic       frame_last;

  modport source (output valid, output median_value, output center_col,
                  output center_row, output frame_last, input ready);
  modport sink (input valid, input median_value, input center_col,
                input center_row, input frame_last, output ready);
endinterface
`default_nettype wire

/* hw/rtl/mf7_cfg_if.sv */
`default_nettype none
interface mf7_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [10:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

/* hw/rtl/mf7_ram.sv */
`default_nettype none
module mf7_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]              rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port and one registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

/* hw/rtl/mf7_front.sv */
`default_nettype none
module mf7_front #(
  parameter int MAX_WIDTH = 1024
) (
  input  wire logic        clk,
  input  wire logic        rst,
  mf7_pix_if.sink          pix_in,
  mf7_cfg_if.sink          cfg,
  input  wire logic        room,
  output logic             push,
  output mf7_pkg::win_item_t push_item
);
  import mf7_pkg::*;

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int WW = CW + 1;
  localparam int LB_W = NLINES * PIX_W;

  logic [CFG_W-1:0]   width_cfg;
  logic [CFG_W-1:0]   height_cfg;
  logic [WW-1:0]      w_eff;
  logic [CFG_W-1:0]   h_eff;
  logic [CW-1:0]      col;
  logic [COORD_W-1:0] row;
  logic               last_col;
  logic               last_row;
  logic               accept;

  logic               s1_valid;
  pix_t               s1_px;
  logic [CW-1:0]      s1_col;
  logic               s1_interior;
  logic [COORD_W-1:0] s1_ccol;
  logic [COORD_W-1:0] s1_crow;
  logic               s1_last;

  logic [LB_W-1:0]    lb_rdata;
  pix_t [NWIN-1:0]    win;
  pix_t [NWIN-1:0]    win_next;
  pix_t [WIN-1:0]     column;

  // Configuration registers; writes are always taken.
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      width_cfg  <= CFG_W'(RESET_DIM);
      height_cfg <= CFG_W'(RESET_DIM);
    end else if (cfg.valid) begin
      case (cfg_reg_t'(cfg.index))
        REG_IMAGE_WIDTH:  width_cfg  <= cfg.data;
        REG_IMAGE_HEIGHT: height_cfg <= cfg.data;
        default: ;
      endcase
    end
  end

  // Saturate the dimensions in use to the supported range.
  always_comb begin
    if (32'(width_cfg) < WIN) begin
      w_eff = WW'(WIN);
    end else if (32'(width_cfg) > MAX_WIDTH) begin
      w_eff = WW'(MAX_WIDTH);
    end else begin
      w_eff = WW'(width_cfg);
    end
    if (32'(height_cfg) < WIN) begin
      h_eff = CFG_W'(WIN);
    end else if (32'(height_cfg) > MAX_HEIGHT) begin
      h_eff = CFG_W'(MAX_HEIGHT);
    end else begin
      h_eff = height_cfg;
    end
  end

  // Accept while the queue can still take the item in flight and this one.
  assign pix_in.ready = room;
  assign accept       = pix_in.valid && pix_in.ready;
  assign last_col     = ({1'b0, col} + WW'(1)) >= w_eff;
  assign last_row     = ({1'b0, row} + CFG_W'(1)) >= h_eff;

  // Raster position counters.
  always_ff @(posedge clk) begin
    if (rst) begin
      col <= '0;
      row <= '0;
    end else if (accept) begin
      if (last_col) begin
        col <= '0;
        row <= last_row ? '0 : row + COORD_W'(1);
      end else begin
        col <= col + CW'(1);
      end
    end
  end

  // Stage one holds the pixel while the line buffer read completes.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_px       <= pix_in.pixel;
      s1_col      <= col;
      s1_interior <= (32'(col) >= NLINES) && (32'(row) >= NLINES);
      s1_ccol     <= COORD_W'(32'(col) - HALF);
      s1_crow     <= COORD_W'(32'(row) - HALF);
      s1_last     <= last_col && last_row;
    end
  end

  // All six previous rows of one column share one memory word.
  mf7_ram #(
    .WIDTH (LB_W),
    .DEPTH (MAX_WIDTH)
  ) u_line_buf (
    .clk   (clk),
    .we    (s1_valid),
    .waddr (s1_col),
    .wdata ({lb_rdata[LB_W-PIX_W-1:0], s1_px}),
    .re    (accept),
    .raddr (col),
    .rdata (lb_rdata)
  );

  // New column has the oldest row on top and the arriving pixel at the bottom.
  always_comb begin
    for (int k = 0; k < NLINES; k++) begin
      column[k] = lb_rdata[(NLINES-1-k)*PIX_W +: PIX_W];
    end
    column[WIN-1] = s1_px;
    for (int r = 0; r < WIN; r++) begin
      for (int c = 0; c < WIN - 1; c++) begin
        win_next[r*WIN+c] = win[r*WIN+c+1];
      end
      win_next[r*WIN+WIN-1] = column[r];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      win <= '0;
    end else if (s1_valid) begin
      win <= win_next;
    end
  end

  // Interior pixels hand their window to the back end.
  assign push           = s1_valid && s1_interior;
  assign push_item.win  = win_next;
  assign push_item.ccol = s1_ccol;
  assign push_item.crow = s1_crow;
  assign push_item.last = s1_last;

endmodule
`default_nettype wire

/* hw/rtl/mf7_fifo.sv */
`default_nettype none
module mf7_fifo (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               push,
  input  wire mf7_pkg::win_item_t push_item,
  input  wire logic               pop,
  output logic                    not_empty,
  output logic                    room,
  output mf7_pkg::win_item_t      head
);
  import mf7_pkg::*;

  localparam int DEPTH = 4;
  localparam int PW = $clog2(DEPTH);

  win_item_t      mem [DEPTH];
  logic [PW-1:0]  wr_ptr;
  logic [PW-1:0]  rd_ptr;
  logic [PW:0]    count;

  assign not_empty = count != '0;
  assign room      = 32'(count) <= DEPTH - 2;
  assign head      = mem[rd_ptr];

  // Queue storage.
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_item;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + PW'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + PW'(1);
      end
      if (push && !pop) begin
        count <= count + (PW+1)'(1);
      end else if (pop && !push) begin
        count <= count - (PW+1)'(1);
      end
    end
  end

endmodule
`default_nettype wire

/* hw/rtl/mf7_median.sv */
`default_nettype none
module mf7_median (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               head_valid,
  input  wire mf7_pkg::win_item_t head,
  output logic                    pop,
  mf7_res_if.source               res_out
);
  import mf7_pkg::*;

  localparam int NST = PIX_W;

  logic             adv;
  logic             st_v    [1:NST];
  win_item_t        st_item [1:NST];
  pix_t             st_pre  [1:NST];
  logic [CNT_W-1:0] st_k    [1:NST];

  // The whole pipeline moves unless the output stage is held.
  assign adv = !st_v[NST] || res_out.ready;
  assign pop = head_valid && adv;

  // One result bit per stage, most significant first.
  for (genvar j = 0; j < NST; j++) begin : g_stage
    logic             in_v;
    win_item_t        in_item;
    pix_t             in_pre;
    logic [CNT_W-1:0] in_k;
    logic [CNT_W-1:0] cnt;

    if (j == 0) begin : g_first
      assign in_v    = head_valid;
      assign in_item = head;
      assign in_pre  = '0;
      assign in_k    = CNT_W'(RANK);
    end else begin : g_next
      assign in_v    = st_v[j];
      assign in_item = st_item[j];
      assign in_pre  = st_pre[j];
      assign in_k    = st_k[j];
    end

    assign cnt = count_low(in_item.win, in_pre, PIX_W - 1 - j);

    always_ff @(posedge clk) begin
      if (rst) begin
        st_v[j+1] <= 1'b0;
      end else if (adv) begin
        st_v[j+1] <= in_v;
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        st_item[j+1] <= in_item;
        if (in_k < cnt) begin
          st_pre[j+1] <= in_pre;
          st_k[j+1]   <= in_k;
        end else begin
          st_pre[j+1] <= in_pre | (PIX_W'(1) << (PIX_W - 1 - j));
          st_k[j+1]   <= in_k - cnt;
        end
      end
    end
  end

  // Last stage is the output register.
  assign res_out.valid        = st_v[NST];
  assign res_out.median_value = st_pre[NST];
  assign res_out.center_col   = st_item[NST].ccol;
  assign res_out.center_row   = st_item[NST].crow;
  assign res_out.frame_last   = st_item[NST].last;

endmodule
`default_nettype wire

/* hw/rtl/median_filter_7x7_top.sv */
// Each accepted pixel passes stage one, the window queue and then the median stages.
// Throughput: one pixel per cycle while the queue has room, set by one line buffer read
// and one write per pixel and the 8-stage median pipeline, which each take one item per
// cycle unless the output is held. Border pixels produce no result. Synchronous active-high
// reset clears counters, the window and all valid state; the line buffer memory is not cleared.
`default_nettype none
module median_filter_7x7_top #(
  parameter int MAX_WIDTH = 1024
) (
  input  wire logic clk,
  input  wire logic rst,
  mf7_pix_if.sink   pix_in,
  mf7_res_if.source res_out,
  mf7_cfg_if.sink   cfg
);
  import mf7_pkg::*;

  logic      push;
  win_item_t push_item;
  logic      room;
  logic      not_empty;
  logic      pop;
  win_item_t head;

  // Front end: counters, line buffers and the window.
  mf7_front #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .pix_in    (pix_in),
    .cfg       (cfg),
    .room      (room),
    .push      (push),
    .push_item (push_item)
  );

  // Short queue of complete windows.
  mf7_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .not_empty (not_empty),
    .room      (room),
    .head      (head)
  );

  // Back end: median selection pipeline.
  mf7_median u_median (
    .clk        (clk),
    .rst        (rst),
    .head_valid (not_empty),
    .head       (head),
    .pop        (pop),
    .res_out    (res_out)
  );

endmodule
`default_nettype wire

/* hw/rtl/mf7_checker.sv */
`default_nettype none
module mf7_checker (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       res_valid,
  input wire logic       res_ready,
  input wire logic [7:0] res_median,
  input wire logic [9:0] res_row
);

  // A held result keeps its value.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(res_median))
    else $error("result changed while stalled");

  // No result is pending right after reset.
  a_reset: assert property (@(posedge clk) $past(rst) && !rst |-> !res_valid)
    else $error("result valid after reset");

  // Only pixels below the top border rows produce results.
  a_row: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> res_row >= 10'd3)
    else $error("result for a border row");

endmodule

bind median_filter_7x7_top mf7_checker u_chk (
  .clk        (clk),
  .rst        (rst),
  .res_valid  (res_out.valid),
  .res_ready  (res_out.ready),
  .res_median (res_out.median_value),
  .res_row    (res_out.center_row)
);
`default_nettype wire
